@@ src/hierarchical_pixel_queue_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pixel queue
// Shared property wrappers on clk and rst_n; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_PIXEL_QUEUE_MACROS_SVH
`define HIERARCHICAL_PIXEL_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define HPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define HPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HPQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/hpq_pkg.sv @@
// ----------------------------------------------------------------------------
// hpq_pkg
// Types, codes and helpers shared by the pixel queue modules.
// ----------------------------------------------------------------------------
package hpq_pkg;

    // Stream payload layout
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 40;
    localparam int LVL_FIELD_W  = 16;
    localparam int COORD_W      = 16;
    localparam int OUT_EMPTY_BIT = 1 + 2 * COORD_W;

    // Non-empty bitmap word
    localparam int BM_W  = 32;
    localparam int BM_SH = 5;

    // Command codes
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RESP
    } hpq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic load_in;
        logic fetch;
        logic exec;
        logic scan_rd;
        logic scan_chk;
        logic respond;
    } hpq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_get;
        logic level_ok;
        logic queue_empty;
        logic level_drain;
        logic word_hit;
        logic last_word;
        logic clear_last;
        logic out_free;
    } hpq_stat_t;

    // Lowest set bit of a bitmap word: {found, index}
    function automatic logic [BM_SH:0] find_first(input logic [BM_W-1:0] word);
        logic [BM_SH:0] res;
        res = '0;
        for (int i = BM_W - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                res = {1'b1, BM_SH'(i)};
            end
        end
        return res;
    endfunction

endpackage

@@ src/hpq_ram.sv @@
// ----------------------------------------------------------------------------
// hpq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/hpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// hpq_ctrl
// Sequencer for the pixel queue: clearing pass, fetch, execute, scan, respond.
// ----------------------------------------------------------------------------
module hpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hpq_pkg::hpq_stat_t stat,
    output hpq_pkg::hpq_cmd_t  cmd
);

    import hpq_pkg::*;

    hpq_state_t state_reg;
    hpq_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                // Refuse an out-of-range put or a get from an empty queue
                if (stat.is_get ? stat.queue_empty : !stat.level_ok)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.is_get && stat.level_drain && !stat.word_hit && !stat.last_word)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                if (stat.word_hit || stat.last_word)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ src/hpq_datapath.sv @@
// ----------------------------------------------------------------------------
// hpq_datapath
// Ring state RAM, coordinate RAM, non-empty bitmap RAM and the lowest pointer.
// ----------------------------------------------------------------------------
`include "hierarchical_pixel_queue_macros.svh"

module hpq_datapath #(
    parameter int LEVELS      = 256,
    parameter int LEVEL_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hpq_pkg::hpq_cmd_t                cmd,
    output hpq_pkg::hpq_stat_t               stat,
    input  logic                             s_tuser,
    input  logic [hpq_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hpq_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import hpq_pkg::*;

    localparam int LW     = $clog2(LEVELS);
    localparam int LNW    = $clog2(LEVELS + 1);
    localparam int HW     = $clog2(LEVEL_DEPTH);
    localparam int CW     = $clog2(LEVEL_DEPTH + 1);
    localparam int SW     = CW + 1;
    localparam int LRW    = HW + CW;
    localparam int NW     = (LEVELS + BM_W - 1) / BM_W;
    localparam int BAW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int CDEPTH = LEVELS * LEVEL_DEPTH;
    localparam int CAW    = $clog2(CDEPTH);

    // Latched item and working registers
    logic                   cmd_reg;
    logic [LVL_FIELD_W-1:0] level_reg;
    logic [COORD_W-1:0]     x_reg;
    logic [COORD_W-1:0]     y_reg;
    logic [LW-1:0]          cur_lvl_reg;
    logic [BAW-1:0]         widx_reg;
    logic [LNW-1:0]         lowest_reg;
    logic [CAW-1:0]         base_reg;
    logic                   done_reg;
    logic [LW-1:0]          clr_reg;
    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;

    // RAM ports
    logic               lr_we;
    logic [LRW-1:0]     lr_wdata;
    logic [LW-1:0]      lr_waddr;
    logic [LRW-1:0]     lr_rdata;
    logic               bm_we;
    logic [BAW-1:0]     bm_waddr;
    logic [BM_W-1:0]    bm_wdata;
    logic [BM_W-1:0]    bm_rdata;
    logic               cr_we;
    logic               cr_re;
    logic [CAW-1:0]     c_addr;
    logic [2*COORD_W-1:0] cr_rdata;

    // Execute-stage arithmetic
    logic [HW-1:0]          head;
    logic [CW-1:0]          cnt;
    logic                   is_get;
    logic                   full;
    logic                   drain;
    logic [SW-1:0]          tail_sum;
    logic [HW-1:0]          tail_slot;
    logic [SW-1:0]          head_inc;
    logic [HW-1:0]          head_next;
    logic [HW-1:0]          slot;
    logic [LVL_FIELD_W-1:0] lvl16;
    logic [BM_W-1:0]        bit_mask;
    logic [BM_W-1:0]        word_chk;
    logic [BM_SH:0]         ff_res;
    logic [LVL_FIELD_W-1:0] found_lvl16;
    logic                   last_word;
    logic                   all_empty;
    logic [COORD_W-1:0]     ox;
    logic [COORD_W-1:0]     oy;

    always_comb
    begin
        is_get    = (cmd_reg == CMD_GET);
        head      = lr_rdata[HW-1:0];
        cnt       = lr_rdata[LRW-1:HW];
        full      = (cnt == CW'(LEVEL_DEPTH));
        drain     = (cnt == CW'(1));

        // Tail slot = head + count, wrapped once
        tail_sum  = SW'(head) + SW'(cnt);
        tail_slot = (tail_sum >= SW'(LEVEL_DEPTH)) ? HW'(tail_sum - SW'(LEVEL_DEPTH))
                                                   : HW'(tail_sum);
        head_inc  = SW'(head) + SW'(1);
        head_next = (head_inc == SW'(LEVEL_DEPTH)) ? '0 : HW'(head_inc);
        slot      = is_get ? head : tail_slot;
        c_addr    = base_reg + CAW'(slot);

        // Bitmap word check: drop the popped level's bit on execute
        lvl16       = LVL_FIELD_W'(cur_lvl_reg);
        bit_mask    = BM_W'(1) << lvl16[BM_SH-1:0];
        word_chk    = cmd.scan_chk ? bm_rdata : (bm_rdata & ~bit_mask);
        ff_res      = find_first(word_chk);
        found_lvl16 = (LVL_FIELD_W'(widx_reg) << BM_SH) | LVL_FIELD_W'(ff_res[BM_SH-1:0]);
        last_word   = (widx_reg == BAW'(NW - 1));
        all_empty   = (lowest_reg == LNW'(LEVELS));

        // Ring state RAM write
        lr_we    = cmd.clear || (cmd.exec && !(!is_get && full));
        lr_waddr = cmd.clear ? clr_reg : cur_lvl_reg;
        if (cmd.clear)
        begin
            lr_wdata = '0;
        end
        else if (is_get)
        begin
            lr_wdata = {cnt - CW'(1), head_next};
        end
        else
        begin
            lr_wdata = {cnt + CW'(1), head};
        end

        // Bitmap RAM write
        bm_we    = (cmd.clear && (LVL_FIELD_W'(clr_reg) < LVL_FIELD_W'(NW)))
                || (cmd.exec && !is_get && !full)
                || (cmd.exec && is_get && drain);
        bm_waddr = cmd.clear ? BAW'(clr_reg) : widx_reg;
        if (cmd.clear)
        begin
            bm_wdata = '0;
        end
        else if (is_get)
        begin
            bm_wdata = word_chk;
        end
        else
        begin
            bm_wdata = bm_rdata | bit_mask;
        end

        // Coordinate RAM
        cr_we = cmd.exec && !is_get && !full;
        cr_re = cmd.exec && is_get;

        // Result fields
        ox = (is_get && done_reg) ? cr_rdata[COORD_W-1:0] : '0;
        oy = (is_get && done_reg) ? cr_rdata[2*COORD_W-1:COORD_W] : '0;
    end

    hpq_ram #(
        .WIDTH (LRW),
        .DEPTH (LEVELS)
    ) u_ring_ram (
        .clk   (clk),
        .we    (lr_we),
        .waddr (lr_waddr),
        .wdata (lr_wdata),
        .re    (cmd.fetch),
        .raddr (cur_lvl_reg),
        .rdata (lr_rdata)
    );

    hpq_ram #(
        .WIDTH (BM_W),
        .DEPTH (NW)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (cmd.fetch || cmd.scan_rd),
        .raddr (widx_reg),
        .rdata (bm_rdata)
    );

    hpq_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (CDEPTH)
    ) u_coord_ram (
        .clk   (clk),
        .we    (cr_we),
        .waddr (c_addr),
        .wdata ({y_reg, x_reg}),
        .re    (cr_re),
        .raddr (c_addr),
        .rdata (cr_rdata)
    );

    // Latch the item and set up addresses
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg   <= s_tuser;
            level_reg <= s_tdata[LVL_FIELD_W-1:0];
            x_reg     <= s_tdata[LVL_FIELD_W+COORD_W-1:LVL_FIELD_W];
            y_reg     <= s_tdata[LVL_FIELD_W+2*COORD_W-1:LVL_FIELD_W+COORD_W];
            if (s_tuser == CMD_PUT)
            begin
                cur_lvl_reg <= LW'(s_tdata[LVL_FIELD_W-1:0]);
            end
            else
            begin
                cur_lvl_reg <= lowest_reg[LW-1:0];
            end
        end
        if (cmd.fetch)
        begin
            base_reg <= CAW'(cur_lvl_reg) * CAW'(LEVEL_DEPTH);
        end
    end

    // Bitmap word index: set on load, advance while scanning
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            if (s_tuser == CMD_PUT)
            begin
                widx_reg <= BAW'(s_tdata[LVL_FIELD_W-1:0] >> BM_SH);
            end
            else
            begin
                widx_reg <= BAW'(LVL_FIELD_W'(lowest_reg) >> BM_SH);
            end
        end
        else if ((cmd.exec && is_get && drain) || cmd.scan_chk)
        begin
            if (!ff_res[BM_SH] && !last_word)
            begin
                widx_reg <= widx_reg + BAW'(1);
            end
        end
    end

    // Lowest non-empty level, done flag and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg <= LNW'(LEVELS);
            done_reg   <= 1'b0;
            clr_reg    <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + LW'(1);
            end
            if (cmd.fetch)
            begin
                done_reg <= 1'b0;
            end
            else if (cmd.exec)
            begin
                done_reg <= is_get || !full;
            end
            // Lower on put, move up after a get drains its level
            if (cmd.exec && !is_get && !full)
            begin
                if (LNW'(cur_lvl_reg) < lowest_reg)
                begin
                    lowest_reg <= LNW'(cur_lvl_reg);
                end
            end
            else if ((cmd.exec && is_get && drain) || cmd.scan_chk)
            begin
                if (ff_res[BM_SH])
                begin
                    lowest_reg <= LNW'(found_lvl16);
                end
                else if (last_word)
                begin
                    lowest_reg <= LNW'(LEVELS);
                end
            end
        end
    end

    // Output register: load on respond, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.respond)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            m_tdata_reg <= OUT_DATA_W'({all_empty, oy, ox, done_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Status to the controller
    always_comb
    begin
        stat.is_get      = is_get;
        stat.level_ok    = (level_reg < LVL_FIELD_W'(LEVELS));
        stat.queue_empty = all_empty;
        stat.level_drain = drain;
        stat.word_hit    = ff_res[BM_SH];
        stat.last_word   = last_word;
        stat.clear_last  = (clr_reg == LW'(LEVELS - 1));
        stat.out_free    = !m_tvalid_reg || m_tready;
    end

    `HPQ_ASSERT_IMPLY(a_lowest_range, 1'b1, lowest_reg <= LNW'(LEVELS),
                      "lowest level out of range")
    `HPQ_ASSERT_NEXT(a_put_not_empty, cmd.respond && !is_get && done_reg,
                     !m_tdata_reg[OUT_EMPTY_BIT], "stored put reported empty queue")
    `HPQ_ASSERT_IMPLY(a_get_refused_empty, cmd.respond && is_get && !done_reg,
                      all_empty, "get refused on a non-empty queue")
    `HPQ_ASSERT_NEXT(a_drain_last_word,
                     cmd.exec && is_get && drain && !ff_res[BM_SH] && last_word,
                     lowest_reg == LNW'(LEVELS), "drain of last word did not empty the queue")

endmodule

@@ src/hierarchical_pixel_queue.sv @@
// ----------------------------------------------------------------------------
// hierarchical_pixel_queue
// Bucket priority queue of x,y pixel pairs, one FIFO ring per grey level.
// ----------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready: s_tuser selects put (0) or get (1),
// s_tdata carries the level and the pair. Every input beat yields exactly one
// output beat on m_tvalid/m_tready with the done flag, the popped pair and the
// all-empty flag.
// An item passes through four steps (accept, ring state read, execute, respond);
// a new input beat is taken only after the previous item has left the respond
// step. A put with a level out of range or a get on an empty queue skips
// execute and goes to respond; a put to a full ring is refused in execute.
// A get that drains its level scans the bitmap upward, a read step and a check
// step for each further 32-level word, until a non-empty word or the last one.
// After reset the block sweeps the ring state and bitmap RAMs to zero, one
// entry per cycle, with s_tready low.
// The result sits in an output register; while the receiver stalls the next
// item may be accepted and processed, and it waits in the respond step until
// the output register frees up.
// ----------------------------------------------------------------------------
module hierarchical_pixel_queue #(
    parameter int LEVELS      = 256,
    parameter int LEVEL_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hpq_pkg::IN_DATA_W-1:0]  s_tdata,   // level[15:0], pos_x[31:16], pos_y[47:32]
    input  logic                           s_tuser,   // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hpq_pkg::OUT_DATA_W-1:0] m_tdata    // done_res[0], out_x[16:1], out_y[32:17],
                                                      // all_empty[33], zero[39:34]
);

    import hpq_pkg::*;

    hpq_cmd_t  cmd;
    hpq_stat_t stat;

    hpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hpq_datapath #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
